FILE: hw/rtl/skf_pkg.sv
`default_nettype none
package skf_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int EST_W     = 28;
  localparam int COV_W     = 26;
  localparam int NOISE_W   = 24;
  localparam int GAIN_W    = 25;
  localparam int FRAC_W    = 24;
  localparam int ERR_W     = EST_W + 1;
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = NOISE_W;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET = 24'd1678;
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RESET = 24'd167772;
  localparam logic [COV_W-1:0]   COV_RESET           = 26'd16777216;
  localparam logic [GAIN_W-1:0]  GAIN_ONE            = 25'd16777216;

  // Product selected for the shared multiplier
  typedef enum logic [1:0] {
    MUL_K_ERR_LO   = 2'd0,
    MUL_K_ERR_HI   = 2'd1,
    MUL_OMK_COV_LO = 2'd2,
    MUL_OMK_COV_HI = 2'd3
  } mul_op_t;

  typedef enum logic [2:0] {
    ACC_NONE   = 3'd0,
    ACC_E_LOAD = 3'd1,
    ACC_E_ADD  = 3'd2,
    ACC_P_LOAD = 3'd3,
    ACC_P_ADD  = 3'd4
  } acc_op_t;

  typedef struct packed {
    logic    load;      // input beat taken
    logic    pred;      // form denominator, seed divider
    logic    div_step;
    logic    div_first;
    mul_op_t mul_op;
    acc_op_t acc_op;
    logic    update;    // commit state and fill output register
  } skf_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/skf_ctrl.sv
`default_nettype none
module skf_ctrl
  import skf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output skf_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_PRED    = 9'b000000010,
    S_DIV     = 9'b000000100,
    S_MUL_ELO = 9'b000001000,
    S_MUL_EHI = 9'b000010000,
    S_MUL_PLO = 9'b000100000,
    S_MUL_PHI = 9'b001000000,
    S_DRAIN   = 9'b010000000,
    S_UPDATE  = 9'b100000000
  } state_t;

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 out_free;

  assign in_stall = rst | (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.mul_op    = MUL_K_ERR_LO;
    cmd.acc_op    = ACC_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PRED;
        end
      end
      S_PRED: begin
        cmd.pred   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (div_cnt == '0);
        if (div_cnt == DIV_LAST) state_next = S_MUL_ELO;
      end
      S_MUL_ELO: begin
        cmd.mul_op = MUL_K_ERR_LO;
        state_next = S_MUL_EHI;
      end
      S_MUL_EHI: begin
        cmd.mul_op = MUL_K_ERR_HI;
        cmd.acc_op = ACC_E_LOAD;
        state_next = S_MUL_PLO;
      end
      S_MUL_PLO: begin
        cmd.mul_op = MUL_OMK_COV_LO;
        cmd.acc_op = ACC_E_ADD;
        state_next = S_MUL_PHI;
      end
      S_MUL_PHI: begin
        cmd.mul_op = MUL_OMK_COV_HI;
        cmd.acc_op = ACC_P_LOAD;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.acc_op = ACC_P_ADD;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.pred) div_cnt <= '0;
      else if (cmd.div_step) div_cnt <= div_cnt + 1'b1;
      if (cmd.update) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/skf_dpath.sv
`default_nettype none
module skf_dpath
  import skf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire skf_cmd_t             cmd,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [SAMPLE_W-1:0]  sample,
  output logic [EST_W-1:0]          estimate,
  output logic [GAIN_W-1:0]         gain
);

  logic [NOISE_W-1:0]  process_noise;
  logic [NOISE_W-1:0]  measure_noise;
  logic [EST_W-1:0]    est_value;
  logic [COV_W-1:0]    est_covariance;

  logic [COV_W-1:0]    p_pred;
  logic [ERR_W-1:0]    err;
  logic [COV_W:0]      den;
  logic                den_zero;
  logic [COV_W:0]      rem;
  logic [GAIN_W-1:0]   quo;

  logic signed [42:0]  prod;
  logic signed [53:0]  acc_e;
  logic [49:0]         acc_p;

  logic [COV_W:0]      p_sum;
  logic [COV_W+1:0]    trial;
  logic                trial_ge;
  logic [GAIN_W-1:0]   k_eff;
  logic [GAIN_W-1:0]   omk;
  logic signed [25:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [53:0]  prod_ext;
  logic [EST_W+1:0]    est_sum;
  logic [EST_W-1:0]    est_value_next;
  logic [COV_W-1:0]    est_covariance_next;

  assign p_sum = {1'b0, est_covariance} + {3'b0, process_noise};

  // restoring divide: first step compares without shifting
  assign trial    = cmd.div_first ? {1'b0, rem} : {rem, 1'b0};
  assign trial_ge = trial >= {1'b0, den};

  assign k_eff = den_zero ? '0 : quo;
  assign omk   = GAIN_ONE - k_eff;

  always_comb begin
    case (cmd.mul_op)
      MUL_K_ERR_LO: begin
        mul_a = {1'b0, k_eff};
        mul_b = {1'b0, err[15:0]};
      end
      MUL_K_ERR_HI: begin
        mul_a = {1'b0, k_eff};
        mul_b = {{4{err[ERR_W-1]}}, err[ERR_W-1:16]};
      end
      MUL_OMK_COV_LO: begin
        mul_a = {1'b0, omk};
        mul_b = {1'b0, p_pred[15:0]};
      end
      MUL_OMK_COV_HI: begin
        mul_a = {1'b0, omk};
        mul_b = {7'b0, p_pred[COV_W-1:16]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_ext = {{11{prod[42]}}, prod};

  // x' = x + floor(K*e / 2^24); arithmetic shift gives the floor
  assign est_sum             = {2'b0, est_value} + acc_e[53:FRAC_W];
  assign est_value_next      = est_sum[EST_W-1:0];
  assign est_covariance_next = acc_p[FRAC_W+COV_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise  <= PROCESS_NOISE_RESET;
      measure_noise  <= MEASURE_NOISE_RESET;
      est_value      <= '0;
      est_covariance <= COV_RESET;
    end else begin
      if (cfg_write && cfg_index == REG_PROCESS_NOISE) process_noise <= cfg_data;
      if (cfg_write && cfg_index == REG_MEASURE_NOISE) measure_noise <= cfg_data;
      if (cmd.update) begin
        est_value      <= est_value_next;
        est_covariance <= est_covariance_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // saturate predicted covariance
      p_pred <= p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];
      err    <= {1'b0, sample, 16'b0} - {1'b0, est_value};
    end
    if (cmd.pred) begin
      den      <= {1'b0, p_pred} + {3'b0, measure_noise};
      den_zero <= (p_pred == '0) && (measure_noise == '0);
      rem      <= {1'b0, p_pred};
    end
    if (cmd.div_step) begin
      // remainder stays below den, so it fits the denominator width
      rem <= trial_ge ? (trial[COV_W:0] - den) : trial[COV_W:0];
      quo <= {quo[GAIN_W-2:0], trial_ge};
    end
    prod <= mul_a * mul_b;
    case (cmd.acc_op)
      ACC_E_LOAD: acc_e <= prod_ext;
      ACC_E_ADD:  acc_e <= acc_e + {prod_ext[37:0], 16'b0};
      ACC_P_LOAD: acc_p <= {7'b0, prod};
      ACC_P_ADD:  acc_p <= acc_p + {prod[33:0], 16'b0};
      default: ;
    endcase
    if (cmd.update) begin
      estimate <= est_value_next;
      gain     <= k_eff;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/scalar_kalman_filter_core.sv
// A sample is taken only in idle; the core then runs the 25-step restoring
// divide for the gain and four passes through the shared 26x17 multiplier, and
// takes no new sample until the result is committed to a free output register.
// A finished result waits in the output register while the next sample runs.
// Reset (synchronous): estimate state 0, covariance 1.0, q and r to their defaults.
`default_nettype none
module scalar_kalman_filter_core
  import skf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SAMPLE_W-1:0]  sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [EST_W-1:0]          estimate,
  output logic [GAIN_W-1:0]         gain
);

  skf_cmd_t cmd;

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  skf_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .estimate  (estimate),
    .gain      (gain)
  );

endmodule
`default_nettype wire
